// File: sv/skf_pkg.sv
`default_nettype none

package skf_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned GAIN_W = 17;
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned CNT_W = 4;
   localparam int unsigned RSP_W = 88;
   localparam int unsigned ADDR_W = 4;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

   typedef enum logic [1:0] {
      REG_PROCESS_NOISE      = 2'd0,
      REG_MEASUREMENT_NOISE  = 2'd1,
      REG_INITIAL_ESTIMATE   = 2'd2,
      REG_INITIAL_COVARIANCE = 2'd3
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PRED = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_MULX = 6'b001000,
      ST_MULP = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// File: sv/scalar_kalman_filter.sv
// A request passes through a predict step, 16 divide steps, 2 multiply passes
// and a writeback step that waits for the output register to be free.
// With zero measurement noise the divide is skipped.
// The rate is set by the radix-2 gain divider and the one shared multiplier.
// A new request is taken once the previous result is in the output register.
// Synchronous active-high reset restores the register defaults and the state.
`default_nettype none

module scalar_kalman_filter #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: [31:0] measurement
   input  wire logic [31:0] req_tdata,
   // request: [0] restart
   input  wire logic        req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // result: [31:0] estimate, [63:32] covariance, [80:64] gain, [87:81] zero
   output logic [87:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [63:0] FIX_ONE = 64'd1 << FRAC_BITS;
   localparam logic [31:0] Q_RESET = 32'((FIX_ONE + 64'd5) / 64'd10);
   localparam logic [31:0] R_RESET = 32'((64'd11 * FIX_ONE + 64'd5) / 64'd10);
   localparam logic [31:0] P_RESET = 32'(FIX_ONE);

   skf_pkg::state_type state_ff, state_in;

   logic [31:0] q_ff, r_ff, x0_ff, p0_ff;
   logic [31:0] est_ff, est_in;
   logic [31:0] cov_ff, cov_in;
   logic [31:0] meas_ff;
   logic        restart_ff;
   logic [31:0] ppred_ff, ppred_in;
   logic [32:0] denom_ff, denom_in;
   logic [33:0] rem_ff, rem_in;
   logic [16:0] gain_ff, gain_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic signed [33:0] innov_ff, innov_in;
   logic signed [51:0] prod_ff, prod_in;
   logic [87:0] rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        csr_wr;
   logic        req_acc;
   logic        out_free;
   logic [31:0] cov_cur, est_cur;
   logic [32:0] psum;
   logic [34:0] dstep;
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [33:0] corr;
   logic signed [34:0] xsum;
   logic [31:0] xsat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign req_tready = (state_ff == skf_pkg::ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      case (skf_pkg::reg_index_type'(csr_paddr[3:2]))
         skf_pkg::REG_PROCESS_NOISE:      csr_prdata = q_ff;
         skf_pkg::REG_MEASUREMENT_NOISE:  csr_prdata = r_ff;
         skf_pkg::REG_INITIAL_ESTIMATE:   csr_prdata = x0_ff;
         skf_pkg::REG_INITIAL_COVARIANCE: csr_prdata = p0_ff;
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff  <= Q_RESET;
         r_ff  <= R_RESET;
         x0_ff <= '0;
         p0_ff <= P_RESET;
      end else if (csr_wr) begin
         case (skf_pkg::reg_index_type'(csr_paddr[3:2]))
            skf_pkg::REG_PROCESS_NOISE:      q_ff  <= csr_pwdata;
            skf_pkg::REG_MEASUREMENT_NOISE:  r_ff  <= csr_pwdata;
            skf_pkg::REG_INITIAL_ESTIMATE:   x0_ff <= csr_pwdata;
            skf_pkg::REG_INITIAL_COVARIANCE: p0_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // restart reloads the state before the update
   assign cov_cur = restart_ff ? p0_ff : cov_ff;
   assign est_cur = restart_ff ? x0_ff : est_ff;
   assign psum    = {1'b0, cov_cur} + {1'b0, q_ff};

   // radix-2 restoring divide step
   assign dstep = {rem_ff, 1'b0} - {2'b00, denom_ff};

   // shared multiplier operands
   always_comb begin
      if (state_ff == skf_pkg::ST_MULP) begin
         mul_a = {2'b00, ppred_ff};
         mul_b = {1'b0, skf_pkg::GAIN_ONE - gain_ff};
      end else begin
         mul_a = innov_ff;
         mul_b = {1'b0, gain_ff};
      end
   end

   assign corr = prod_ff[49:16];
   assign xsum = {{3{est_ff[31]}}, est_ff} + {corr[33], corr};
   always_comb begin
      if (!xsum[34] && (xsum[33:31] != 3'b000)) xsat = 32'h7FFF_FFFF;
      else if (xsum[34] && (xsum[33:31] != 3'b111)) xsat = 32'h8000_0000;
      else xsat = xsum[31:0];
   end

   always_comb begin
      state_in     = state_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      ppred_in     = ppred_ff;
      denom_in     = denom_ff;
      rem_in       = rem_ff;
      gain_in      = gain_ff;
      cnt_in       = cnt_ff;
      innov_in     = innov_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         skf_pkg::ST_IDLE: begin
            if (req_acc) state_in = skf_pkg::ST_PRED;
         end
         skf_pkg::ST_PRED: begin
            est_in   = est_cur;
            ppred_in = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
            denom_in = {1'b0, ppred_in} + {1'b0, r_ff};
            innov_in = {{2{meas_ff[31]}}, meas_ff} - {{2{est_cur[31]}}, est_cur};
            rem_in   = {2'b00, ppred_in};
            cnt_in   = '0;
            if (r_ff == '0) begin
               gain_in  = (ppred_in != '0) ? skf_pkg::GAIN_ONE : '0;
               state_in = skf_pkg::ST_MULX;
            end else begin
               gain_in  = '0;
               state_in = skf_pkg::ST_DIV;
            end
         end
         skf_pkg::ST_DIV: begin
            if (!dstep[34]) begin
               rem_in  = dstep[33:0];
               gain_in = {gain_ff[15:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[32:0], 1'b0};
               gain_in = {gain_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(skf_pkg::DIV_STEPS - 1)) state_in = skf_pkg::ST_MULX;
         end
         skf_pkg::ST_MULX: begin
            prod_in  = mul_a * mul_b;
            state_in = skf_pkg::ST_MULP;
         end
         skf_pkg::ST_MULP: begin
            est_in   = xsat;
            prod_in  = mul_a * mul_b;
            state_in = skf_pkg::ST_DONE;
         end
         skf_pkg::ST_DONE: begin
            if (out_free) begin
               cov_in       = prod_ff[47:16];
               rsp_in       = {7'b0, gain_ff, prod_ff[47:16], est_ff};
               rsp_valid_in = 1'b1;
               state_in     = skf_pkg::ST_IDLE;
            end
         end
         default: state_in = skf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::ST_IDLE;
         est_ff       <= '0;
         cov_ff       <= P_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         meas_ff    <= req_tdata;
         restart_ff <= req_tuser;
      end
      ppred_ff <= ppred_in;
      denom_ff <= denom_in;
      rem_ff   <= rem_in;
      gain_ff  <= gain_in;
      cnt_ff   <= cnt_in;
      innov_ff <= innov_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == skf_pkg::ST_DONE |-> gain_ff <= skf_pkg::GAIN_ONE)
      else $error("gain above one");

   a_cov_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == skf_pkg::ST_DONE |-> prod_ff[51:48] == 4'b0 && prod_ff[47:16] <= ppred_ff)
      else $error("covariance update above prediction");

   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == skf_pkg::ST_PRED)
      else $error("request did not start the update");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == skf_pkg::ST_DONE && out_free |=> rsp_valid_ff && req_tready)
      else $error("finished update not presented");
`endif

endmodule

`default_nettype wire

// File: tb/skf_checker.sv
module skf_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [87:0] rsp_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic [31:0] csr_prdata,
   input  wire logic        csr_pready,
   output int               failures,
   output int               waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] estimate;
      logic [31:0] covariance;
      logic [16:0] gain;
   } kf_result_type;

   logic [31:0] q_noise;
   logic [31:0] r_noise;
   logic [31:0] init_est;
   logic [31:0] init_cov;
   logic [31:0] est_state;
   logic [31:0] cov_state;
   kf_result_type pending_results[$];
   int          err_count = 0;

   function automatic kf_result_type predict_step(input logic [31:0] x, input logic [31:0] p,
                                                  input logic [31:0] z);
      longint unsigned ppred;
      longint unsigned denom;
      longint unsigned g;
      longint unsigned pn;
      longint          innov;
      longint          xn;
      kf_result_type   res;
      ppred = p;
      ppred = ppred + q_noise;
      if (ppred > 64'hFFFF_FFFF) ppred = 64'hFFFF_FFFF;
      denom = ppred + r_noise;
      g = (denom == 0) ? 64'd0 : (ppred << 16) / denom;
      innov = longint'($signed(z)) - longint'($signed(x));
      xn = longint'($signed(x)) + ((innov * longint'(g)) >>> 16);
      if (xn > 64'sd2147483647) xn = 64'sd2147483647;
      if (xn < -64'sd2147483648) xn = -64'sd2147483648;
      pn = ((64'd65536 - g) * ppred) >> 16;
      res.estimate = xn[31:0];
      res.covariance = pn[31:0];
      res.gain = g[16:0];
      return res;
   endfunction

   function automatic logic [31:0] reg_value(input skf_pkg::reg_index_type idx);
      case (idx)
         skf_pkg::REG_PROCESS_NOISE:     return q_noise;
         skf_pkg::REG_MEASUREMENT_NOISE: return r_noise;
         skf_pkg::REG_INITIAL_ESTIMATE:  return init_est;
         default:                        return init_cov;
      endcase
   endfunction

   task automatic report(input string what, input logic [87:0] want, input logic [87:0] got);
      err_count++;
      if (err_count <= 10) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      kf_result_type want;
      kf_result_type res;
      skf_pkg::reg_index_type idx;
      if (reset) begin
         q_noise = 32'd6554;
         r_noise = 32'd72090;
         init_est = 32'd0;
         init_cov = 32'h0001_0000;
         est_state = init_est;
         cov_state = init_cov;
         pending_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            idx = skf_pkg::reg_index_type'(csr_paddr[3:2]);
            if (csr_pwrite) begin
               case (idx)
                  skf_pkg::REG_PROCESS_NOISE:      q_noise = csr_pwdata;
                  skf_pkg::REG_MEASUREMENT_NOISE:  r_noise = csr_pwdata;
                  skf_pkg::REG_INITIAL_ESTIMATE:   init_est = csr_pwdata;
                  skf_pkg::REG_INITIAL_COVARIANCE: init_cov = csr_pwdata;
                  default: ;
               endcase
            end else if (csr_prdata !== reg_value(idx)) begin
               report($sformatf("register %0d read", idx), reg_value(idx), csr_prdata);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report("unexpected result", '0, rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[31:0] !== want.estimate)
                  report("estimate", want.estimate, rsp_tdata[31:0]);
               if (rsp_tdata[63:32] !== want.covariance)
                  report("covariance", want.covariance, rsp_tdata[63:32]);
               if (rsp_tdata[80:64] !== want.gain)
                  report("gain", want.gain, rsp_tdata[80:64]);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               est_state = init_est;
               cov_state = init_cov;
            end
            res = predict_step(est_state, cov_state, req_tdata);
            est_state = res.estimate;
            cov_state = res.covariance;
            pending_results.push_back(res);
         end
      end
      failures <= err_count;
      waiting <= pending_results.size();
   end

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 30;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_REQUESTS = 85;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int waiting;
   int idle_cycles = 0;
   int rsp_stall = 0;
   bit fast_req = 1'b0;
   bit fast_rsp = 1'b0;

   always #4 clock = ~clock;

   scalar_kalman_filter dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   skf_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready),
      .failures(failures), .waiting(waiting)
   );

   // result stall counts down only while a result is offered
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         draw = fast_rsp ? 0 : $urandom_range(0, 5);
         rsp_stall <= draw;
         rsp_tready <= (draw == 0);
      end else if (!rsp_tready && (rsp_stall == 0 || rsp_tvalid)) begin
         if (rsp_stall <= 1) rsp_tready <= 1'b1;
         if (rsp_stall != 0) rsp_stall <= rsp_stall - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("scalar_kalman_filter verification failed");
            $finish;
         end
      end
   end

   task automatic csr_access(input bit write, input skf_pkg::reg_index_type idx,
                             input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] q, input logic [31:0] r,
                               input logic [31:0] x0, input logic [31:0] p0);
      csr_access(1'b1, skf_pkg::REG_PROCESS_NOISE, q);
      csr_access(1'b1, skf_pkg::REG_MEASUREMENT_NOISE, r);
      csr_access(1'b1, skf_pkg::REG_INITIAL_ESTIMATE, x0);
      csr_access(1'b1, skf_pkg::REG_INITIAL_COVARIANCE, p0);
      csr_access(1'b0, skf_pkg::REG_PROCESS_NOISE, '0);
      csr_access(1'b0, skf_pkg::REG_MEASUREMENT_NOISE, '0);
      csr_access(1'b0, skf_pkg::REG_INITIAL_ESTIMATE, '0);
      csr_access(1'b0, skf_pkg::REG_INITIAL_COVARIANCE, '0);
   endtask

   task automatic send_request(input logic [31:0] measurement, input bit restart);
      int gap;
      gap = fast_req ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= measurement;
      req_tuser <= restart;
      do @(posedge clock); while (!req_tready);
   endtask

   // drain all results, then give the datapath time to go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_variance();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(0, 32'h0004_0000);
         3, 4:    return $urandom_range(0, 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_signed();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // power-on defaults
      send_request(32'h0000_0000, 1'b0);
      send_request(32'h7FFF_FFFF, 1'b0);
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h8000_0000, 1'b1);
      send_request(32'h7FFF_FFFF, 1'b1);
      send_request(32'hFFFF_FFFF, 1'b0);
      send_request(32'h0000_0001, 1'b0);
      settle();

      // zero denominator: gain stays zero
      program_regs(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0);
      send_request(32'h8000_0000, 1'b1);
      send_request(32'h0000_0000, 1'b0);
      send_request(32'h1234_5678, 1'b0);
      settle();

      // covariance saturation
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(32'h7FFF_FFFF, 1'b1);
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h0000_0000, 1'b0);
      settle();

      // no measurement noise: gain of one
      program_regs(32'h0001_0000, 32'd0, 32'h8000_0000, 32'd0);
      send_request(32'h7FFF_FFFF, 1'b1);
      send_request(32'h8000_0000, 1'b0);
      send_request(32'h0000_0005, 1'b0);
      settle();
      program_regs(32'd0, 32'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(32'h8000_0000, 1'b1);
      send_request(32'h7FFF_FFFF, 1'b0);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         fast_req = ($urandom_range(0, 3) == 0);
         fast_rsp <= ($urandom_range(0, 3) == 0);
         program_regs(pick_variance(), pick_variance(), pick_signed(), pick_variance());
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            send_request(pick_signed(), ($urandom_range(0, 7) == 0));
         end
         settle();
      end

      if (failures == 0 && waiting == 0) begin
         $display("scalar_kalman_filter verification clean");
      end else begin
         $display("scalar_kalman_filter verification failed");
      end
      $finish;
   end

endmodule
